// ----- sv/ehp_pkg.sv -----
// Types and constants for the Ethernet IPv4 L4 header parser.
package ehp_pkg;

   localparam int LENGTH_BITS = 14;
   localparam int SNAP_BITS = 14;
   localparam int CMP_BITS = (LENGTH_BITS > SNAP_BITS) ? LENGTH_BITS : SNAP_BITS;

   typedef logic [LENGTH_BITS-1:0] pos_type;
   typedef logic [SNAP_BITS-1:0] snap_type;

   localparam pos_type COUNT_MAX = {LENGTH_BITS{1'b1}};
   localparam snap_type SNAP_RESET = SNAP_BITS'(1514);

   localparam pos_type POS_ETHER_HI = LENGTH_BITS'(12);
   localparam pos_type POS_ETHER_LO = LENGTH_BITS'(13);
   localparam pos_type POS_VERSION = LENGTH_BITS'(14);
   localparam pos_type POS_TOTAL_HI = LENGTH_BITS'(16);
   localparam pos_type POS_TOTAL_LO = LENGTH_BITS'(17);
   localparam pos_type POS_PROTOCOL = LENGTH_BITS'(23);
   localparam pos_type POS_SOURCE_FIRST = LENGTH_BITS'(26);
   localparam pos_type POS_SOURCE_LAST = LENGTH_BITS'(29);
   localparam pos_type POS_DEST_FIRST = LENGTH_BITS'(30);
   localparam pos_type POS_DEST_LAST = LENGTH_BITS'(33);

   localparam pos_type OFF_SPORT_LAST = LENGTH_BITS'(1);
   localparam pos_type OFF_DPORT_FIRST = LENGTH_BITS'(2);
   localparam pos_type OFF_DPORT_LAST = LENGTH_BITS'(3);
   localparam pos_type OFF_ULEN_FIRST = LENGTH_BITS'(4);
   localparam pos_type OFF_ULEN_LAST = LENGTH_BITS'(5);
   localparam pos_type OFF_TCP_OFFSET = LENGTH_BITS'(12);

   localparam logic [7:0] ETH_HDR = 8'd14;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [3:0] IP_VERSION_4 = 4'd4;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [15:0] IP_HDR_MIN = 16'd20;
   localparam logic [15:0] TCP_HDR_MIN = 16'd20;
   localparam logic [15:0] TCP_HDR_MAX = 16'd60;
   localparam logic [15:0] UDP_HDR = 16'd8;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [31:0] capture_seconds;
   } req_type;

   typedef struct packed {
      logic [31:0] stamp_seconds;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [13:0] frame_length;
      logic [7:0]  protocol_number;
   } rsp_type;

   typedef struct packed {
      logic [15:0] ether_kind;
      logic [7:0]  ip_version_header;
      logic [15:0] ip_total_length;
      logic [7:0]  ip_protocol_seen;
      logic [31:0] ip_source_seen;
      logic [31:0] ip_dest_seen;
      logic [15:0] port_source_seen;
      logic [15:0] port_dest_seen;
      logic [7:0]  tcp_offset_byte;
      logic [15:0] udp_length_seen;
   } frame_type;

   typedef struct packed {
      frame_type   fields;
      snap_type    frame_length;
      logic [31:0] stamp_seconds;
   } close_type;

endpackage

// ----- sv/eth_ipv4_l4_header_parser.sv -----
// Top level: byte-wise Ethernet / IPv4 / TCP-UDP header parser with summary record.
// The last byte of a frame loads the close stage, which feeds the result register.
// Throughput: one byte per cycle; field capture is one compare-and-load per byte.
// The close stage and the result register decouple the output; a held result
// stalls input only once both are full.
// Reset clears the byte counter, header fields, pipeline valids; snap length -> 1514.
module eth_ipv4_l4_header_parser
   import ehp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data,
   input  logic     csr_write_enable,
   input  snap_type csr_write_data
);

   snap_type  snap_ff;
   pos_type   pos_ff, pos_in;
   frame_type frame_ff, frame_in;
   logic      close_valid_ff;
   close_type close_ff, close_in;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff, rsp_in;

   logic      req_accept;
   logic      close_advance;
   pos_type   count;
   pos_type   l4_start;
   pos_type   offset;
   logic      in_window;
   frame_type caught;
   logic [CMP_BITS-1:0] len_wide;

   logic [SNAP_BITS-1:0] dsize;
   logic [5:0]  hlen;
   logic [5:0]  th;
   logic [15:0] l4size;
   logic        ip_ok;
   logic        l4_ok;

   assign close_advance = close_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !close_valid_ff || close_advance;
   assign req_accept = req_valid && req_ready;

   // capture header bytes at their positions
   always_comb begin
      caught = frame_ff;
      in_window = CMP_BITS'(pos_ff) < CMP_BITS'(snap_ff);
      l4_start = LENGTH_BITS'(ETH_HDR)
               + LENGTH_BITS'({frame_ff.ip_version_header[3:0], 2'b00});
      offset = pos_ff - l4_start;
      if (in_window) begin
         if (pos_ff == POS_ETHER_HI || pos_ff == POS_ETHER_LO) begin
            caught.ether_kind = {frame_ff.ether_kind[7:0], req_data.data_byte};
         end
         if (pos_ff == POS_VERSION) begin
            caught.ip_version_header = req_data.data_byte;
         end
         if (pos_ff == POS_TOTAL_HI || pos_ff == POS_TOTAL_LO) begin
            caught.ip_total_length = {frame_ff.ip_total_length[7:0], req_data.data_byte};
         end
         if (pos_ff == POS_PROTOCOL) begin
            caught.ip_protocol_seen = req_data.data_byte;
         end
         if (pos_ff >= POS_SOURCE_FIRST && pos_ff <= POS_SOURCE_LAST) begin
            caught.ip_source_seen = {frame_ff.ip_source_seen[23:0], req_data.data_byte};
         end
         if (pos_ff >= POS_DEST_FIRST && pos_ff <= POS_DEST_LAST) begin
            caught.ip_dest_seen = {frame_ff.ip_dest_seen[23:0], req_data.data_byte};
         end
         if (pos_ff > POS_VERSION && pos_ff >= l4_start) begin
            if (offset <= OFF_SPORT_LAST) begin
               caught.port_source_seen = {frame_ff.port_source_seen[7:0], req_data.data_byte};
            end
            if (offset == OFF_DPORT_FIRST || offset == OFF_DPORT_LAST) begin
               caught.port_dest_seen = {frame_ff.port_dest_seen[7:0], req_data.data_byte};
            end
            if (offset == OFF_ULEN_FIRST || offset == OFF_ULEN_LAST) begin
               caught.udp_length_seen = {frame_ff.udp_length_seen[7:0], req_data.data_byte};
            end
            if (offset == OFF_TCP_OFFSET) begin
               caught.tcp_offset_byte = req_data.data_byte;
            end
         end
      end
   end

   always_comb begin
      count = (pos_ff < COUNT_MAX) ? pos_ff + pos_type'(1) : COUNT_MAX;
      len_wide = (CMP_BITS'(count) < CMP_BITS'(snap_ff)) ? CMP_BITS'(count)
                                                         : CMP_BITS'(snap_ff);
      pos_in = count;
      frame_in = caught;
      if (req_data.last_byte) begin
         pos_in = '0;
         frame_in = '0;
      end
      close_in.fields = caught;
      close_in.frame_length = len_wide[SNAP_BITS-1:0];
      close_in.stamp_seconds = req_data.capture_seconds;
   end

   // validate the closed frame and build the record
   always_comb begin
      dsize = close_ff.frame_length - SNAP_BITS'(ETH_HDR);
      hlen = {close_ff.fields.ip_version_header[3:0], 2'b00};
      th = {close_ff.fields.tcp_offset_byte[7:4], 2'b00};
      l4size = close_ff.fields.ip_total_length - 16'(hlen);
      ip_ok = close_ff.frame_length >= SNAP_BITS'(ETH_HDR)
           && close_ff.fields.ether_kind == ETHERTYPE_IPV4
           && 16'(dsize) >= IP_HDR_MIN
           && close_ff.fields.ip_version_header[7:4] == IP_VERSION_4
           && 16'(hlen) >= IP_HDR_MIN
           && 16'(hlen) <= close_ff.fields.ip_total_length
           && 16'(dsize) >= close_ff.fields.ip_total_length;
      l4_ok = 1'b0;
      if (close_ff.fields.ip_protocol_seen == PROTO_TCP) begin
         l4_ok = l4size >= TCP_HDR_MIN && 16'(th) >= TCP_HDR_MIN
              && 16'(th) <= l4size && 16'(th) <= TCP_HDR_MAX;
      end else if (close_ff.fields.ip_protocol_seen == PROTO_UDP) begin
         l4_ok = l4size >= UDP_HDR && close_ff.fields.udp_length_seen >= UDP_HDR
              && close_ff.fields.udp_length_seen <= l4size;
      end
      rsp_in = '0;
      rsp_in.stamp_seconds = close_ff.stamp_seconds;
      rsp_in.frame_length = 14'(close_ff.frame_length);
      if (ip_ok) begin
         rsp_in.source_address = close_ff.fields.ip_source_seen;
         rsp_in.dest_address = close_ff.fields.ip_dest_seen;
         rsp_in.protocol_number = close_ff.fields.ip_protocol_seen;
         if (l4_ok) begin
            rsp_in.source_port = close_ff.fields.port_source_seen;
            rsp_in.dest_port = close_ff.fields.port_dest_seen;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_ff <= SNAP_RESET;
         pos_ff <= '0;
         frame_ff <= '0;
         close_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            snap_ff <= csr_write_data;
         end
         if (req_accept) begin
            pos_ff <= pos_in;
            frame_ff <= frame_in;
         end
         if (req_accept && req_data.last_byte) begin
            close_valid_ff <= 1'b1;
         end else if (close_advance) begin
            close_valid_ff <= 1'b0;
         end
         if (close_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_data.last_byte) begin
         close_ff <= close_in;
      end
      if (close_advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ----- sv/ehp_checker.sv -----
// Port-level checker for the header parser, bound to the top level.
module ehp_checker
   import ehp_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input req_type  req_data,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input rsp_type  rsp_data
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("held item changed before it was taken");

   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("item shown right after reset");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_data.last_byte, 2))
      else $error("item not caused by a last byte two cycles earlier");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.protocol_number != PROTO_TCP
      && rsp_data.protocol_number != PROTO_UDP
      |-> rsp_data.source_port == 16'd0 && rsp_data.dest_port == 16'd0)
      else $error("ports decoded for a protocol other than TCP or UDP");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_length < 14'd34
      |-> rsp_data.source_address == 32'd0 && rsp_data.dest_address == 32'd0
          && rsp_data.protocol_number == 8'd0)
      else $error("IPv4 fields decoded from a frame too short for the header");

endmodule

bind eth_ipv4_l4_header_parser ehp_checker u_ehp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- bench/ehp_frame_checker.sv -----
// Checker for the header parser: predicts one summary record per frame and compares it.
`timescale 1ns / 1ps
module ehp_frame_checker
   import ehp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_ready,
   input  req_type  req_data,
   input  logic     rsp_valid,
   input  logic     rsp_ready,
   input  rsp_type  rsp_data,
   input  logic     csr_write_enable,
   input  snap_type csr_write_data,
   output int       pending,
   output int       fail_count
);

   snap_type  snap_limit;
   pos_type   byte_count;
   frame_type seen;
   rsp_type   expected_records[$];
   int        mismatches;

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_record(input rsp_type got);
      rsp_type want;
      if (expected_records.size() == 0) begin
         $error("record with no closed frame waiting: %h", got);
         mismatches++;
      end else begin
         want = expected_records.pop_front();
         compare_field("stamp_seconds", want.stamp_seconds, got.stamp_seconds);
         compare_field("source_address", want.source_address, got.source_address);
         compare_field("dest_address", want.dest_address, got.dest_address);
         compare_field("source_port", want.source_port, got.source_port);
         compare_field("dest_port", want.dest_port, got.dest_port);
         compare_field("frame_length", want.frame_length, got.frame_length);
         compare_field("protocol_number", want.protocol_number, got.protocol_number);
      end
   endfunction

   function automatic void absorb_byte(input req_type item);
      int      at;
      int      l4_start;
      int      offset;
      int      frame_len;
      int      ip_payload;
      int      header_len;
      int      ip_len;
      int      l4_size;
      int      tcp_len;
      bit      ports_ok;
      rsp_type rec;
      at = int'(byte_count);
      l4_start = int'(ETH_HDR) + 4 * int'(seen.ip_version_header[3:0]);
      if (byte_count < snap_limit) begin
         if (byte_count == POS_ETHER_HI || byte_count == POS_ETHER_LO)
            seen.ether_kind = {seen.ether_kind[7:0], item.data_byte};
         if (byte_count == POS_VERSION)
            seen.ip_version_header = item.data_byte;
         if (byte_count == POS_TOTAL_HI || byte_count == POS_TOTAL_LO)
            seen.ip_total_length = {seen.ip_total_length[7:0], item.data_byte};
         if (byte_count == POS_PROTOCOL)
            seen.ip_protocol_seen = item.data_byte;
         if (byte_count >= POS_SOURCE_FIRST && byte_count <= POS_SOURCE_LAST)
            seen.ip_source_seen = {seen.ip_source_seen[23:0], item.data_byte};
         if (byte_count >= POS_DEST_FIRST && byte_count <= POS_DEST_LAST)
            seen.ip_dest_seen = {seen.ip_dest_seen[23:0], item.data_byte};
         if (at > int'(POS_VERSION) && at >= l4_start) begin
            offset = at - l4_start;
            if (offset <= int'(OFF_SPORT_LAST))
               seen.port_source_seen = {seen.port_source_seen[7:0], item.data_byte};
            if (offset >= int'(OFF_DPORT_FIRST) && offset <= int'(OFF_DPORT_LAST))
               seen.port_dest_seen = {seen.port_dest_seen[7:0], item.data_byte};
            if (offset >= int'(OFF_ULEN_FIRST) && offset <= int'(OFF_ULEN_LAST))
               seen.udp_length_seen = {seen.udp_length_seen[7:0], item.data_byte};
            if (offset == int'(OFF_TCP_OFFSET))
               seen.tcp_offset_byte = item.data_byte;
         end
      end
      if (byte_count != COUNT_MAX)
         byte_count = byte_count + 1'b1;
      if (item.last_byte) begin
         frame_len = (byte_count < snap_limit) ? int'(byte_count) : int'(snap_limit);
         rec = '0;
         rec.stamp_seconds = item.capture_seconds;
         rec.frame_length = 14'(frame_len);
         if (frame_len >= int'(ETH_HDR) && seen.ether_kind == ETHERTYPE_IPV4) begin
            ip_payload = frame_len - int'(ETH_HDR);
            header_len = 4 * int'(seen.ip_version_header[3:0]);
            ip_len = int'(seen.ip_total_length);
            if (ip_payload >= int'(IP_HDR_MIN) &&
                seen.ip_version_header[7:4] == IP_VERSION_4 &&
                header_len >= int'(IP_HDR_MIN) && header_len <= ip_len &&
                ip_payload >= ip_len) begin
               l4_size = ip_len - header_len;
               rec.source_address = seen.ip_source_seen;
               rec.dest_address = seen.ip_dest_seen;
               rec.protocol_number = seen.ip_protocol_seen;
               ports_ok = 1'b0;
               if (seen.ip_protocol_seen == PROTO_TCP) begin
                  tcp_len = 4 * int'(seen.tcp_offset_byte[7:4]);
                  ports_ok = l4_size >= int'(TCP_HDR_MIN) && tcp_len >= int'(TCP_HDR_MIN) &&
                             tcp_len <= l4_size && tcp_len <= int'(TCP_HDR_MAX);
               end else if (seen.ip_protocol_seen == PROTO_UDP) begin
                  ports_ok = l4_size >= int'(UDP_HDR) &&
                             int'(seen.udp_length_seen) >= int'(UDP_HDR) &&
                             int'(seen.udp_length_seen) <= l4_size;
               end
               if (ports_ok) begin
                  rec.source_port = seen.port_source_seen;
                  rec.dest_port = seen.port_dest_seen;
               end
            end
         end
         expected_records.push_back(rec);
         byte_count = '0;
         seen = '0;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         snap_limit = SNAP_RESET;
         byte_count = '0;
         seen = '0;
         expected_records.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_record(rsp_data);
         if (csr_write_enable)
            snap_limit = csr_write_data;
         if (req_valid && req_ready)
            absorb_byte(req_data);
      end
      pending <= expected_records.size();
      fail_count <= mismatches;
   end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top: clock, reset, frame stimulus, snap length phases, stalls and verdict.
`timescale 1ns / 1ps
module tb_top;
   import ehp_pkg::*;

   typedef enum int {SHAPE_TCP, SHAPE_UDP, SHAPE_OTHER, SHAPE_NOT_IPV4, SHAPE_SHORT,
                     SHAPE_NOISE} frame_shape_type;
   typedef enum int {FLAW_NONE, FLAW_VERSION, FLAW_IHL, FLAW_TOTAL_LONG, FLAW_TOTAL_SHORT,
                     FLAW_TCP_OFFSET, FLAW_UDP_LENGTH, FLAW_CUT} frame_flaw_type;
   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_type;

   localparam int PHASES = 9;
   localparam int PHASE_BYTES = 130;
   localparam int PHASE_FRAMES = 2;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT = 4000;

   logic     clock;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   req_type  req_data = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   rsp_type  rsp_data;
   logic     csr_write_enable = 1'b0;
   snap_type csr_write_data = '0;
   int       pending;
   int       fail_count;

   int         stall_pct = 0;
   int         send_idle = 0;
   int         bytes_sent = 0;
   int         frames_sent = 0;
   int         quiet_cycles = 0;
   logic [7:0] frame_bytes[$];
   snap_type   snap_plan[PHASES];

   eth_ipv4_l4_header_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   ehp_frame_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .pending          (pending),
      .fail_count       (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [31:0] field_value(input fill_type fill);
      logic [31:0] word;
      case (fill)
         FILL_ZERO: word = '0;
         FILL_ONES: word = '1;
         default: begin
            case ($urandom_range(7))
               0: word = '0;
               1: word = '1;
               default: word = $urandom();
            endcase
         end
      endcase
      return word;
   endfunction

   function automatic void build_frame(input frame_shape_type shape,
                                       input frame_flaw_type flaw,
                                       input int payload_len, input int pad_len,
                                       input fill_type fill);
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [15:0] ether;
      logic [15:0] total_len;
      logic [15:0] udp_len;
      logic [3:0]  version;
      logic [3:0]  ihl;
      logic [3:0]  doff;
      logic [3:0]  doff_field;
      logic [7:0]  proto;
      int          hdr_bytes;
      int          l4_len;
      int          cut;
      frame_bytes = {};
      if (shape == SHAPE_SHORT) begin
         repeat (1 + payload_len % 13) frame_bytes.push_back(8'($urandom_range(255)));
      end else if (shape == SHAPE_NOISE) begin
         repeat (1 + payload_len + $urandom_range(60))
            frame_bytes.push_back(8'($urandom_range(255)));
         if (frame_bytes.size() > 14 && $urandom_range(1)) begin
            frame_bytes[12] = ETHERTYPE_IPV4[15:8];
            frame_bytes[13] = ETHERTYPE_IPV4[7:0];
         end
      end else begin
         src_addr = field_value(fill);
         dst_addr = field_value(fill);
         src_port = 16'(field_value(fill));
         dst_port = 16'(field_value(fill));
         ether = ETHERTYPE_IPV4;
         if (shape == SHAPE_NOT_IPV4)
            ether = ETHERTYPE_IPV4 ^ 16'($urandom_range(65535, 1));
         version = IP_VERSION_4;
         ihl = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 6)) : 4'd5;
         doff = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 6)) : 4'd5;
         case (shape)
            SHAPE_UDP: proto = PROTO_UDP;
            SHAPE_OTHER: begin
               proto = 8'($urandom_range(255));
               while (proto == PROTO_TCP || proto == PROTO_UDP)
                  proto = 8'($urandom_range(255));
            end
            default: proto = PROTO_TCP;
         endcase
         doff_field = doff;
         udp_len = 16'(int'(UDP_HDR) + payload_len);
         case (flaw)
            FLAW_VERSION: version = IP_VERSION_4 ^ 4'($urandom_range(15, 1));
            FLAW_IHL: ihl = 4'($urandom_range(4));
            FLAW_TCP_OFFSET: doff_field = 4'($urandom_range(4));
            FLAW_UDP_LENGTH: udp_len = 16'($urandom_range(65535));
            default: ;
         endcase
         hdr_bytes = (ihl > 5) ? 4 * ihl : int'(IP_HDR_MIN);
         l4_len = (proto == PROTO_TCP) ? 4 * doff : (proto == PROTO_UDP) ? int'(UDP_HDR) : 0;
         total_len = 16'(hdr_bytes + l4_len + payload_len);
         if (flaw == FLAW_TOTAL_LONG)
            total_len = total_len + 16'($urandom_range(200, 1));
         if (flaw == FLAW_TOTAL_SHORT)
            total_len = 16'($urandom_range(int'(total_len)));
         repeat (12) frame_bytes.push_back(8'($urandom_range(255)));
         frame_bytes.push_back(ether[15:8]);
         frame_bytes.push_back(ether[7:0]);
         frame_bytes.push_back({version, ihl});
         frame_bytes.push_back(8'($urandom_range(255)));
         frame_bytes.push_back(total_len[15:8]);
         frame_bytes.push_back(total_len[7:0]);
         repeat (5) frame_bytes.push_back(8'($urandom_range(255)));
         frame_bytes.push_back(proto);
         repeat (2) frame_bytes.push_back(8'($urandom_range(255)));
         for (int k = 3; k >= 0; k--) frame_bytes.push_back(src_addr[8*k +: 8]);
         for (int k = 3; k >= 0; k--) frame_bytes.push_back(dst_addr[8*k +: 8]);
         repeat (hdr_bytes - int'(IP_HDR_MIN)) frame_bytes.push_back(8'($urandom_range(255)));
         if (proto == PROTO_TCP || proto == PROTO_UDP) begin
            frame_bytes.push_back(src_port[15:8]);
            frame_bytes.push_back(src_port[7:0]);
            frame_bytes.push_back(dst_port[15:8]);
            frame_bytes.push_back(dst_port[7:0]);
         end
         if (proto == PROTO_TCP) begin
            repeat (8) frame_bytes.push_back(8'($urandom_range(255)));
            frame_bytes.push_back({doff_field, 4'($urandom_range(15))});
            repeat (4 * doff - 13) frame_bytes.push_back(8'($urandom_range(255)));
         end else if (proto == PROTO_UDP) begin
            frame_bytes.push_back(udp_len[15:8]);
            frame_bytes.push_back(udp_len[7:0]);
            repeat (2) frame_bytes.push_back(8'($urandom_range(255)));
         end
         repeat (payload_len + pad_len) frame_bytes.push_back(8'($urandom_range(255)));
         if (flaw == FLAW_CUT) begin
            cut = $urandom_range(frame_bytes.size(), 1);
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
         end
      end
   endfunction

   task automatic send_byte(input logic [7:0] data, input logic is_last);
      logic [31:0] stamp;
      case ($urandom_range(7))
         0: stamp = '0;
         1: stamp = '1;
         default: stamp = $urandom();
      endcase
      req_data <= '{data_byte: data, last_byte: is_last, capture_seconds: stamp};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
   endtask

   task automatic send_frame(input frame_shape_type shape, input frame_flaw_type flaw,
                             input int payload_len, input int pad_len, input fill_type fill);
      build_frame(shape, flaw, payload_len, pad_len, fill);
      for (int i = 0; i < frame_bytes.size(); i++)
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      frames_sent++;
   endtask

   task automatic send_random_frame();
      int              pick;
      frame_shape_type shape;
      frame_flaw_type  flaw;
      int              payload_len;
      int              pad_len;
      pick = $urandom_range(99);
      if (pick < 40) shape = SHAPE_TCP;
      else if (pick < 75) shape = SHAPE_UDP;
      else if (pick < 82) shape = SHAPE_OTHER;
      else if (pick < 88) shape = SHAPE_NOT_IPV4;
      else if (pick < 94) shape = SHAPE_SHORT;
      else shape = SHAPE_NOISE;
      flaw = FLAW_NONE;
      if ($urandom_range(3) == 0)
         flaw = frame_flaw_type'($urandom_range(int'(FLAW_CUT), int'(FLAW_VERSION)));
      payload_len = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(16);
      pad_len = ($urandom_range(3) == 0) ? $urandom_range(12, 1) : 0;
      send_frame(shape, flaw, payload_len, pad_len, FILL_RANDOM);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int phase_start;
      int phase_frames;
      snap_plan = '{SNAP_RESET, 16383, 14, 0, 60, 13, 38, 0, SNAP_RESET};
      snap_plan[7] = snap_type'($urandom_range(16383, 14));
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_drained();
            csr_write_data <= snap_plan[phase];
            csr_write_enable <= 1'b1;
            @(posedge clock);
            csr_write_enable <= 1'b0;
         end
         case (phase % 4)
            0: begin send_idle = 0; stall_pct <= 0; end
            1: begin send_idle = 59; stall_pct <= 0; end
            2: begin send_idle = 0; stall_pct <= 59; end
            default: begin send_idle = 21; stall_pct <= 21; end
         endcase
         if (phase == 0) begin
            send_frame(SHAPE_SHORT, FLAW_NONE, 0, 0, FILL_RANDOM);
            send_frame(SHAPE_SHORT, FLAW_NONE, 12, 0, FILL_RANDOM);
            send_frame(SHAPE_TCP, FLAW_NONE, 0, 0, FILL_ONES);
            send_frame(SHAPE_UDP, FLAW_NONE, 0, 0, FILL_ZERO);
            send_frame(SHAPE_OTHER, FLAW_NONE, 0, 0, FILL_RANDOM);
            send_frame(SHAPE_NOT_IPV4, FLAW_NONE, 0, 0, FILL_RANDOM);
         end
         phase_start = bytes_sent;
         phase_frames = 0;
         while (bytes_sent - phase_start < PHASE_BYTES || phase_frames < PHASE_FRAMES) begin
            send_random_frame();
            phase_frames++;
         end
      end
      wait_drained();
      $display("Sent %0d frame bytes in %0d frames over %0d snap lengths,",
               bytes_sent, frames_sent, PHASES);
      $display("with short, truncated, flawed and non-IPv4 frames under four stall mixes.");
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
sv/ehp_pkg.sv
sv/eth_ipv4_l4_header_parser.sv
sv/ehp_checker.sv
bench/ehp_frame_checker.sv
bench/tb_top.sv
